// ===== design/hct_pkg.sv =====
// hct_pkg: shared types and constants of the heightmap cell triangulator
// depends on nothing; used by every module of the block
`default_nettype none

package hct_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_CELLS_ACROSS = 3'd0;
    localparam logic [2:0] CFG_CELLS_DOWN   = 3'd1;
    localparam logic [2:0] CFG_CELL_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_CELL_DEPTH   = 3'd3;
    localparam logic [2:0] CFG_CENTER_X     = 3'd4;
    localparam logic [2:0] CFG_CENTER_Y     = 3'd5;
    localparam logic [2:0] CFG_CENTER_Z     = 3'd6;

    // unit normal length in Q1.14 and vertex slot bounds
    localparam logic signed [15:0] UNIT_NORMAL = 16'sd16384;
    localparam logic [2:0] LAST_SLOT = 3'd5;

    // per-slot corner selection, bit s belongs to slot s
    localparam logic [5:0] SLOT_DX = 6'b110100;
    localparam logic [5:0] SLOT_DZ = 6'b010110;
    localparam logic [5:0] SLOT_U  = 6'b110100;
    localparam logic [5:0] SLOT_V  = 6'b010110;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef struct packed {
        logic [10:0]        cells_across;
        logic [10:0]        cells_down;
        logic [30:0]        cell_width;
        logic [30:0]        cell_depth;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
    } t_cfg;

    // saturated corner positions of one cell
    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] x1;
        logic signed [31:0] z0;
        logic signed [31:0] z1;
        logic signed [31:0] y00;
        logic signed [31:0] y10;
        logic signed [31:0] y01;
        logic signed [31:0] y11;
    } t_entry;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec3;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_nrm;

    typedef struct packed {
        logic busy;
        logic done;
    } t_nrm_status;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        t_nrm               n;
        logic               u;
        logic               v;
        logic [2:0]         slot;
        logic               last;
    } t_vertex;

    typedef enum logic [2:0] {
        N_IDLE,
        N_CROSS,
        N_SHRINK,
        N_SQUARE,
        N_SQRT,
        N_DLOAD,
        N_DIV
    } t_nrm_state;

    typedef enum logic {
        B_IDLE,
        B_WAIT
    } t_back_state;

endpackage

`default_nettype wire

// ===== design/heightmap_cell_triangulator.sv =====
// heightmap_cell_triangulator: top level, configuration registers and wiring
// depends on hct_pkg, hct_front, hct_fifo, hct_back
//
// channel   direction  handshake        payload
// config    in         i_cfg_we         i_cfg_idx, i_cfg_data
// cell      in         push / full      cell_col, cell_row, four corner heights
// vertex    out        empty / pop      position, normal, texture, slot, last flag
//
// a cell enters while full is low; up to five wait behind the one in work, one in
// the front stage and four in the queue; full rises when both are occupied
// from queue to first vertex a cell passes through the two sequential normal units
// (six cross terms, up to 30 shrink steps, bit-serial square root, three
// restoring divides); a zero cross product ends its unit after the first shrink
// check; six vertices leave at one per cycle while pop is held, overlapped
// reset is synchronous; no memory sweep, configuration takes its reset values
`default_nettype none

module heightmap_cell_triangulator #(
    parameter int MAX_CELLS_PER_SIDE = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [9:0]         i_cell_col,
    input  wire logic [9:0]         i_cell_row,
    input  wire logic signed [31:0] i_corner_h00,
    input  wire logic signed [31:0] i_corner_h10,
    input  wire logic signed [31:0] i_corner_h01,
    input  wire logic signed [31:0] i_corner_h11,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      o_vertex_x,
    output logic signed [31:0]      o_vertex_y,
    output logic signed [31:0]      o_vertex_z,
    output logic signed [15:0]      o_normal_x,
    output logic signed [15:0]      o_normal_y,
    output logic signed [15:0]      o_normal_z,
    output logic                    o_tex_u,
    output logic                    o_tex_v,
    output logic [2:0]              o_corner_slot,
    output logic                    o_last_vertex
);

    hct_pkg::t_cfg r_cfg;
    hct_pkg::t_entry q_in, q_out;
    hct_pkg::t_vertex vtx;
    logic q_wr, q_rd, q_full, q_empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cells_across <= 11'd64;
            r_cfg.cells_down   <= 11'd64;
            r_cfg.cell_width   <= 31'd65536;
            r_cfg.cell_depth   <= 31'd65536;
            r_cfg.center_x     <= '0;
            r_cfg.center_y     <= '0;
            r_cfg.center_z     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hct_pkg::CFG_CELLS_ACROSS: r_cfg.cells_across <= i_cfg_data[10:0];
                hct_pkg::CFG_CELLS_DOWN:   r_cfg.cells_down   <= i_cfg_data[10:0];
                hct_pkg::CFG_CELL_WIDTH:   r_cfg.cell_width   <= i_cfg_data[30:0];
                hct_pkg::CFG_CELL_DEPTH:   r_cfg.cell_depth   <= i_cfg_data[30:0];
                hct_pkg::CFG_CENTER_X:     r_cfg.center_x     <= i_cfg_data;
                hct_pkg::CFG_CENTER_Y:     r_cfg.center_y     <= i_cfg_data;
                hct_pkg::CFG_CENTER_Z:     r_cfg.center_z     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hct_front #(
        .MAX_CELLS_PER_SIDE(MAX_CELLS_PER_SIDE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .o_full      (full),
        .i_cell_col  (i_cell_col),
        .i_cell_row  (i_cell_row),
        .i_corner_h00(i_corner_h00),
        .i_corner_h10(i_corner_h10),
        .i_corner_h01(i_corner_h01),
        .i_corner_h11(i_corner_h11),
        .o_wr        (q_wr),
        .o_entry     (q_in),
        .i_qfull     (q_full)
    );

    hct_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (q_wr),
        .i_data (q_in),
        .i_rd   (q_rd),
        .o_data (q_out),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    hct_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (q_out),
        .i_qempty(q_empty),
        .o_qrd   (q_rd),
        .o_empty (empty),
        .i_pop   (pop),
        .o_vertex(vtx)
    );

    assign o_vertex_x    = vtx.vx;
    assign o_vertex_y    = vtx.vy;
    assign o_vertex_z    = vtx.vz;
    assign o_normal_x    = vtx.n.x;
    assign o_normal_y    = vtx.n.y;
    assign o_normal_z    = vtx.n.z;
    assign o_tex_u       = vtx.u;
    assign o_tex_v       = vtx.v;
    assign o_corner_slot = vtx.slot;
    assign o_last_vertex = vtx.last;

`ifndef SYNTHESIS
    // slot stays within the six vertices of a cell
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_corner_slot <= hct_pkg::LAST_SLOT))
        else $error("vertex slot out of range");

    // a taken non-final vertex is followed by the next slot of the same cell
    a_slot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last_vertex) |=>
        (!empty && o_corner_slot == $past(o_corner_slot) + 3'd1))
        else $error("vertex sequence broken");

    // normal x and y components never exceed unit length
    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_normal_x <= hct_pkg::UNIT_NORMAL && o_normal_x >= -hct_pkg::UNIT_NORMAL
                 && o_normal_y <= hct_pkg::UNIT_NORMAL && o_normal_y >= -hct_pkg::UNIT_NORMAL))
        else $error("normal out of range");
`endif

endmodule

`default_nettype wire

// ===== design/hct_fifo.sv =====
// hct_fifo: short queue of cell entries between front and back
// depends on hct_pkg
`default_nettype none

module hct_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire hct_pkg::t_entry i_data,
    input  wire logic            i_rd,
    output hct_pkg::t_entry      o_data,
    output logic                 o_full,
    output logic                 o_empty
);

    hct_pkg::t_entry r_mem [hct_pkg::QDEPTH];
    logic [hct_pkg::QPTR_W-1:0] r_wptr, r_rptr;
    logic [hct_pkg::QPTR_W:0]   r_count;
    logic do_wr, do_rd;

    assign o_full  = (r_count == (hct_pkg::QPTR_W+1)'(hct_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) r_wptr <= r_wptr + 1'b1;
            if (do_rd) r_rptr <= r_rptr + 1'b1;
            if (do_wr && !do_rd) r_count <= r_count + 1'b1;
            else if (do_rd && !do_wr) r_count <= r_count - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wptr] <= i_data;
    end

endmodule

`default_nettype wire

// ===== design/hct_front.sv =====
// hct_front: accepts cells and forms the saturated corner positions
// depends on hct_pkg; writes into hct_fifo
`default_nettype none

module hct_front #(
    parameter int MAX_CELLS_PER_SIDE = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hct_pkg::t_cfg      i_cfg,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic [9:0]         i_cell_col,
    input  wire logic [9:0]         i_cell_row,
    input  wire logic signed [31:0] i_corner_h00,
    input  wire logic signed [31:0] i_corner_h10,
    input  wire logic signed [31:0] i_corner_h01,
    input  wire logic signed [31:0] i_corner_h11,
    output logic                    o_wr,
    output hct_pkg::t_entry         o_entry,
    input  wire logic               i_qfull
);

    function automatic logic [10:0] clamp_count(logic [10:0] n);
        if (n == '0) return 11'd1;
        if ({21'd0, n} > 32'(MAX_CELLS_PER_SIDE)) return 11'(MAX_CELLS_PER_SIDE);
        return n;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [45:0] s);
        if (s[45:31] == '0 || s[45:31] == '1) return s[31:0];
        return s[45] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

    logic stall, accept;
    logic [10:0] nx, nz;
    logic signed [12:0] dx, dz;
    logic r_v1;
    logic signed [44:0] r_tx, r_tz;
    logic signed [31:0] r_h00, r_h10, r_h01, r_h11;
    logic signed [45:0] sx0, sx1, sz0, sz1;

    assign stall  = r_v1 && i_qfull;
    assign o_full = stall;
    assign accept = i_push && !stall;

    // offset of the cell's low corner from the grid center, in cell units doubled
    assign nx = clamp_count(i_cfg.cells_across);
    assign nz = clamp_count(i_cfg.cells_down);
    assign dx = $signed({2'b0, i_cell_col, 1'b0}) - $signed({2'b0, nx});
    assign dz = $signed({2'b0, i_cell_row, 1'b0}) - $signed({2'b0, nz});

    // stage one: products of offset and cell size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (!stall) begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tx  <= dx * $signed({1'b0, i_cfg.cell_width});
            r_tz  <= dz * $signed({1'b0, i_cfg.cell_depth});
            r_h00 <= i_corner_h00;
            r_h10 <= i_corner_h10;
            r_h01 <= i_corner_h01;
            r_h11 <= i_corner_h11;
        end
    end

    // stage two: halve with floor, far corner is one cell further, saturate
    assign sx0 = 46'(i_cfg.center_x) + 46'(r_tx >>> 1);
    assign sx1 = sx0 + 46'($signed({1'b0, i_cfg.cell_width}));
    assign sz0 = 46'(i_cfg.center_z) + 46'(r_tz >>> 1);
    assign sz1 = sz0 + 46'($signed({1'b0, i_cfg.cell_depth}));

    assign o_wr          = r_v1 && !i_qfull;
    assign o_entry.x0    = sat32(sx0);
    assign o_entry.x1    = sat32(sx1);
    assign o_entry.z0    = sat32(sz0);
    assign o_entry.z1    = sat32(sz1);
    assign o_entry.y00   = sat32(46'(i_cfg.center_y) + 46'(r_h00));
    assign o_entry.y10   = sat32(46'(i_cfg.center_y) + 46'(r_h10));
    assign o_entry.y01   = sat32(46'(i_cfg.center_y) + 46'(r_h01));
    assign o_entry.y11   = sat32(46'(i_cfg.center_y) + 46'(r_h11));

endmodule

`default_nettype wire

// ===== design/hct_normal.sv =====
// hct_normal: sequential face normal unit, one shared multiplier,
// bit-serial square root and restoring divide; depends on hct_pkg
`default_nettype none

module hct_normal (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire hct_pkg::t_vec3 i_a,
    input  wire hct_pkg::t_vec3 i_b,
    input  wire hct_pkg::t_vec3 i_c,
    output hct_pkg::t_nrm_status o_status,
    output hct_pkg::t_nrm       o_normal
);

    function automatic logic [32:0] mag33(logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    // magnitude truncated toward zero by k bits, sign kept
    function automatic logic signed [30:0] trunc_tz(logic signed [32:0] v, logic [1:0] k);
        logic [32:0] m;
        m = mag33(v) >> k;
        return v[32] ? -$signed(31'(m)) : $signed(31'(m));
    endfunction

    function automatic logic [1:0] shift_k(logic [32:0] m);
        if (m[32]) return 2'd3;
        if (m[31]) return 2'd2;
        if (m[30]) return 2'd1;
        return 2'd0;
    endfunction

    hct_pkg::t_nrm_state r_state, n_state;
    logic r_done;
    logic [2:0] r_step;
    logic signed [30:0] r_e1 [3];
    logic signed [30:0] r_e2 [3];
    logic signed [63:0] r_acc;
    logic [61:0] r_mag [3];
    logic r_neg [3];
    logic [63:0] r_sum, r_rem, r_bit;
    logic [64:0] r_root;
    logic [31:0] r_len;
    logic [45:0] r_drem;
    logic [14:0] r_q;
    logic [1:0] r_comp;
    logic [3:0] r_i;
    logic signed [15:0] r_n [3];

    logic signed [32:0] d1 [3];
    logic signed [32:0] d2 [3];
    logic [1:0] k1, k2;
    logic signed [30:0] sel_a, sel_b;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod, xdiff;
    logic [61:0] mag_or;
    logic all_zero, too_wide;
    logic [64:0] trial;
    logic [45:0] den;
    logic [14:0] q_next;
    logic take;

    // edge vectors, shrunk below 2^30
    assign d1[0] = 33'(i_b.x) - 33'(i_a.x);
    assign d1[1] = 33'(i_b.y) - 33'(i_a.y);
    assign d1[2] = 33'(i_b.z) - 33'(i_a.z);
    assign d2[0] = 33'(i_c.x) - 33'(i_b.x);
    assign d2[1] = 33'(i_c.y) - 33'(i_b.y);
    assign d2[2] = 33'(i_c.z) - 33'(i_b.z);
    assign k1 = shift_k(mag33(d1[0]) | mag33(d1[1]) | mag33(d1[2]));
    assign k2 = shift_k(mag33(d2[0]) | mag33(d2[1]) | mag33(d2[2]));

    // cross product operand order, two products per component
    always_comb begin
        unique case (r_step)
            3'd0:    begin sel_a = r_e1[1]; sel_b = r_e2[2]; end
            3'd1:    begin sel_a = r_e1[2]; sel_b = r_e2[1]; end
            3'd2:    begin sel_a = r_e1[2]; sel_b = r_e2[0]; end
            3'd3:    begin sel_a = r_e1[0]; sel_b = r_e2[2]; end
            3'd4:    begin sel_a = r_e1[0]; sel_b = r_e2[1]; end
            default: begin sel_a = r_e1[1]; sel_b = r_e2[0]; end
        endcase
    end

    // shared multiplier: signed cross terms or squares of magnitudes
    always_comb begin
        if (r_state == hct_pkg::N_SQUARE) begin
            mul_a = {1'b0, r_mag[r_step[1:0]][30:0]};
            mul_b = {1'b0, r_mag[r_step[1:0]][30:0]};
        end else begin
            mul_a = {sel_a[30], sel_a};
            mul_b = {sel_b[30], sel_b};
        end
    end
    assign prod  = mul_a * mul_b;
    assign xdiff = r_acc - prod;

    assign mag_or   = r_mag[0] | r_mag[1] | r_mag[2];
    assign all_zero = (mag_or == '0);
    assign too_wide = (mag_or[61:31] != '0);

    assign trial  = r_root + {1'b0, r_bit};
    assign den    = 46'(r_len) << r_i;
    assign take   = (r_drem >= den);
    assign q_next = take ? (r_q | (15'd1 << r_i)) : r_q;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hct_pkg::N_IDLE:   if (i_start) n_state = hct_pkg::N_CROSS;
            hct_pkg::N_CROSS:  if (r_step == 3'd5) n_state = hct_pkg::N_SHRINK;
            hct_pkg::N_SHRINK: begin
                if (all_zero) n_state = hct_pkg::N_IDLE;
                else if (!too_wide) n_state = hct_pkg::N_SQUARE;
            end
            hct_pkg::N_SQUARE: if (r_step == 3'd2) n_state = hct_pkg::N_SQRT;
            hct_pkg::N_SQRT:   if (r_bit == '0) n_state = hct_pkg::N_DLOAD;
            hct_pkg::N_DLOAD:  n_state = hct_pkg::N_DIV;
            hct_pkg::N_DIV: begin
                if (r_i == '0) n_state = (r_comp == 2'd2) ? hct_pkg::N_IDLE
                                                          : hct_pkg::N_DLOAD;
            end
            default: n_state = hct_pkg::N_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hct_pkg::N_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == hct_pkg::N_IDLE && i_start) r_done <= 1'b0;
            else if (r_state != hct_pkg::N_IDLE && n_state == hct_pkg::N_IDLE)
                r_done <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            hct_pkg::N_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    r_e1[i] <= trunc_tz(d1[i], k1);
                    r_e2[i] <= trunc_tz(d2[i], k2);
                end
                r_step <= '0;
            end
            hct_pkg::N_CROSS: begin
                if (!r_step[0]) begin
                    r_acc <= prod;
                end else begin
                    r_neg[r_step[2:1]] <= xdiff[63];
                    r_mag[r_step[2:1]] <= xdiff[63] ? 62'(-xdiff) : 62'(xdiff);
                end
                r_step <= r_step + 1'b1;
            end
            hct_pkg::N_SHRINK: begin
                if (all_zero) begin
                    r_n[0] <= '0;
                    r_n[1] <= hct_pkg::UNIT_NORMAL;
                    r_n[2] <= '0;
                end else if (too_wide) begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                end
                r_step <= '0;
                r_sum  <= '0;
            end
            hct_pkg::N_SQUARE: begin
                r_sum  <= r_sum + 64'(prod);
                r_rem  <= r_sum + 64'(prod);
                r_root <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
                r_step <= r_step + 1'b1;
            end
            hct_pkg::N_SQRT: begin
                if (r_bit != '0) begin
                    if ({1'b0, r_rem} >= trial) begin
                        r_rem  <= r_rem - trial[63:0];
                        r_root <= (r_root >> 1) + {1'b0, r_bit};
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                r_len  <= r_root[31:0];
                r_comp <= '0;
            end
            hct_pkg::N_DLOAD: begin
                r_drem <= {r_mag[r_comp][30:0], 14'd0} + 46'(r_len >> 1);
                r_q    <= '0;
                r_i    <= 4'd14;
            end
            hct_pkg::N_DIV: begin
                if (take) r_drem <= r_drem - den;
                r_q <= q_next;
                r_i <= r_i - 1'b1;
                if (r_i == '0) begin
                    r_n[r_comp] <= r_neg[r_comp] ? -$signed({1'b0, q_next})
                                                 : $signed({1'b0, q_next});
                    r_comp <= r_comp + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_status.busy = (r_state != hct_pkg::N_IDLE);
    assign o_status.done = r_done;
    assign o_normal.x    = r_n[0];
    assign o_normal.y    = r_n[1];
    assign o_normal.z    = r_n[2];

endmodule

`default_nettype wire

// ===== design/hct_back.sv =====
// hct_back: takes cells from the queue, runs both face normals,
// streams six vertices from an output register; depends on hct_pkg, hct_normal
`default_nettype none

module hct_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire hct_pkg::t_entry i_entry,
    input  wire logic            i_qempty,
    output logic                 o_qrd,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output hct_pkg::t_vertex     o_vertex
);

    hct_pkg::t_back_state r_state, n_state;
    hct_pkg::t_entry r_cell, r_emit;
    hct_pkg::t_nrm r_na, r_nb;
    hct_pkg::t_nrm na, nb;
    hct_pkg::t_nrm_status st_a, st_b;
    hct_pkg::t_vec3 p0, p1, p2, p5;
    logic r_start, r_ev;
    logic [2:0] r_slot;
    logic both_done, slot_free, load_emit, pop_ok;

    // corners of the two triangles
    assign p0 = '{x: r_cell.x0, y: r_cell.y00, z: r_cell.z0};
    assign p1 = '{x: r_cell.x0, y: r_cell.y01, z: r_cell.z1};
    assign p2 = '{x: r_cell.x1, y: r_cell.y11, z: r_cell.z1};
    assign p5 = '{x: r_cell.x1, y: r_cell.y10, z: r_cell.z0};

    hct_normal u_norm_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_a     (p0),
        .i_b     (p1),
        .i_c     (p2),
        .o_status(st_a),
        .o_normal(na)
    );

    hct_normal u_norm_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_a     (p0),
        .i_b     (p2),
        .i_c     (p5),
        .o_status(st_b),
        .o_normal(nb)
    );

    assign pop_ok    = i_pop && r_ev;
    assign slot_free = !r_ev || (pop_ok && r_slot == hct_pkg::LAST_SLOT);
    assign both_done = !r_start && st_a.done && st_b.done && !st_a.busy && !st_b.busy;
    assign load_emit = (r_state == hct_pkg::B_WAIT) && both_done && slot_free;

    // sequencer: fetch, compute, hand over to the output register
    always_comb begin
        n_state = r_state;
        o_qrd   = 1'b0;
        unique case (r_state)
            hct_pkg::B_IDLE: begin
                if (!i_qempty) begin
                    o_qrd   = 1'b1;
                    n_state = hct_pkg::B_WAIT;
                end
            end
            hct_pkg::B_WAIT: if (load_emit) n_state = hct_pkg::B_IDLE;
            default: n_state = hct_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hct_pkg::B_IDLE;
            r_start <= 1'b0;
            r_ev    <= 1'b0;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_start <= o_qrd;
            if (load_emit) begin
                r_ev   <= 1'b1;
                r_slot <= '0;
            end else if (pop_ok) begin
                if (r_slot == hct_pkg::LAST_SLOT) r_ev <= 1'b0;
                else r_slot <= r_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_qrd) r_cell <= i_entry;
        if (load_emit) begin
            r_emit <= r_cell;
            r_na   <= na;
            r_nb   <= nb;
        end
    end

    // vertex selection by slot
    always_comb begin
        o_vertex.vx = r_emit.x0;
        if (hct_pkg::SLOT_DX[r_slot]) o_vertex.vx = r_emit.x1;
        o_vertex.vz = r_emit.z0;
        if (hct_pkg::SLOT_DZ[r_slot]) o_vertex.vz = r_emit.z1;
        unique case (r_slot)
            3'd1:    o_vertex.vy = r_emit.y01;
            3'd2:    o_vertex.vy = r_emit.y11;
            3'd4:    o_vertex.vy = r_emit.y11;
            3'd5:    o_vertex.vy = r_emit.y10;
            default: o_vertex.vy = r_emit.y00;
        endcase
        o_vertex.n    = (r_slot < 3'd3) ? r_na : r_nb;
        o_vertex.u    = hct_pkg::SLOT_U[r_slot];
        o_vertex.v    = hct_pkg::SLOT_V[r_slot];
        o_vertex.slot = r_slot;
        o_vertex.last = (r_slot == hct_pkg::LAST_SLOT);
    end

    assign o_empty = !r_ev;

endmodule

`default_nettype wire
